[src/mpsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants of the multi-pattern stream matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FOUND_W = 4;

  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h01;

  typedef enum logic [REQ_W-1:0] {
    REQ_STREAM = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_ARM    = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef struct packed {
    logic deliver;
    logic wr_en;
    logic arm;
    logic clear;
  } slot_cmd_t;

endpackage

[src/multi_pattern_stream_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_stream_matcher
// Unescapes a byte stream and matches it against up to SLOTS loaded strings.
//
//   Channel  Handshake               Payload
//   in       in_valid_i / in_ready_o req_type_i, slot_i, position_i, value_i
//   out      out_valid_o/ out_ready_i found_slot_o
//
// An item is registered on entry and processed from there; every stream byte
// item yields one registered result, so one item per cycle is sustained while
// results are taken. All slots compare the byte in parallel; each slot's
// character store is read ahead at its next match count.
// Reset clears counts, lengths, armed flags and the escape flag; stored
// characters are not cleared. A stream byte waits in the input register
// while the result register is held by the consumer.
// ----------------------------------------------------------------------------
module multi_pattern_stream_matcher #(
  parameter int unsigned SLOTS           = 10,
  parameter int unsigned MAX_PATTERN_LEN = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mpsm_pkg::REQ_W-1:0]      req_type_i,
  input  logic [mpsm_pkg::SLOT_W-1:0]     slot_i,
  input  logic [mpsm_pkg::POS_W-1:0]      position_i,
  input  logic [mpsm_pkg::BYTE_W-1:0]     value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mpsm_pkg::FOUND_W-1:0]    found_slot_o
);

  localparam int unsigned CW = $clog2(MAX_PATTERN_LEN + 1);

  logic                          s1_valid_q, s1_valid_d;
  logic [mpsm_pkg::REQ_W-1:0]    s1_req_q;
  logic [mpsm_pkg::SLOT_W-1:0]   s1_slot_q;
  logic [mpsm_pkg::POS_W-1:0]    s1_pos_q;
  logic [mpsm_pkg::BYTE_W-1:0]   s1_value_q;
  logic                          esc_q, esc_d;
  logic                          out_valid_q, out_valid_d;
  logic [mpsm_pkg::FOUND_W-1:0]  found_q, found_d, found;

  logic                          s1_go, in_accept;
  logic                          is_byte, is_write, is_arm, is_clear;
  logic                          deliver, slot_ok, pos_ok, found_any;
  logic [mpsm_pkg::BYTE_W-1:0]   slot_data;
  logic [CW-1:0]                 arm_len;
  logic [SLOTS-1:0]              hits;
  mpsm_pkg::slot_cmd_t           cmds [SLOTS];

  always_comb begin
    is_byte  = 1'b0;
    is_write = 1'b0;
    is_arm   = 1'b0;
    is_clear = 1'b0;
    unique case (mpsm_pkg::req_e'(s1_req_q))
      mpsm_pkg::REQ_STREAM: is_byte  = 1'b1;
      mpsm_pkg::REQ_WRITE:  is_write = 1'b1;
      mpsm_pkg::REQ_ARM:    is_arm   = 1'b1;
      mpsm_pkg::REQ_CLEAR:  is_clear = 1'b1;
      default:              is_clear = 1'b0;
    endcase
  end

  assign s1_go      = s1_valid_q && (!is_byte || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_accept  = in_valid_i && in_ready_o;

  assign deliver   = s1_go && is_byte && (esc_q || (s1_value_q != mpsm_pkg::ESC_BYTE));
  assign slot_data = (is_byte && esc_q) ? (s1_value_q - 8'd1) : s1_value_q;
  assign slot_ok   = {1'b0, s1_slot_q} < (mpsm_pkg::SLOT_W + 1)'(SLOTS);
  assign pos_ok    = {2'b00, s1_pos_q} < (mpsm_pkg::POS_W + 2)'(MAX_PATTERN_LEN);
  assign arm_len   = ({1'b0, s1_value_q} > 9'(MAX_PATTERN_LEN)) ?
                     CW'(MAX_PATTERN_LEN) : s1_value_q[CW-1:0];

  assign found_any = |hits;

  always_comb begin
    found = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (hits[s]) begin
        found = mpsm_pkg::FOUND_W'(s + 1);
      end
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : gen_slot
    logic sel;
    assign sel = s1_go && slot_ok && (s1_slot_q == mpsm_pkg::SLOT_W'(g));
    assign cmds[g].deliver = deliver;
    assign cmds[g].wr_en   = sel && is_write && pos_ok;
    assign cmds[g].arm     = sel && is_arm;
    assign cmds[g].clear   = (s1_go && is_clear) || found_any;

    mpsm_slot #(
      .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_slot (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmds[g]),
      .data_i    (slot_data),
      .pos_i     (s1_pos_q),
      .arm_len_i (arm_len),
      .hit_o     (hits[g])
    );
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    esc_d = esc_q;
    if (s1_go && is_byte) begin
      esc_d = esc_q ? 1'b0 : (s1_value_q == mpsm_pkg::ESC_BYTE);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    found_d     = found_q;
    if (s1_go && is_byte) begin
      out_valid_d = 1'b1;
      found_d     = found;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q   <= req_type_i;
      s1_slot_q  <= slot_i;
      s1_pos_q   <= position_i;
      s1_value_q <= value_i;
    end
    found_q <= found_d;
  end

  assign out_valid_o  = out_valid_q;
  assign found_slot_o = found_q;

endmodule

[src/mpsm_slot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_slot
// One pattern slot: character store, length, armed flag and match count.
// ----------------------------------------------------------------------------
module mpsm_slot #(
  parameter int unsigned MAX_PATTERN_LEN = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mpsm_pkg::slot_cmd_t                  cmd_i,
  input  logic [mpsm_pkg::BYTE_W-1:0]          data_i,
  input  logic [mpsm_pkg::POS_W-1:0]           pos_i,
  input  logic [$clog2(MAX_PATTERN_LEN+1)-1:0] arm_len_i,
  output logic                                 hit_o
);

  localparam int unsigned CW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int unsigned PW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

  logic [mpsm_pkg::BYTE_W-1:0] mem [MAX_PATTERN_LEN];
  logic [mpsm_pkg::BYTE_W-1:0] rd_q;
  logic [mpsm_pkg::BYTE_W-1:0] first_q;
  logic [CW-1:0]               count_q, count_d, count_new;
  logic [CW-1:0]               len_q, len_d;
  logic                        armed_q, armed_d;
  logic [PW-1:0]               wr_addr, rd_addr;
  logic                        active;

  assign wr_addr = PW'(pos_i);
  assign active  = cmd_i.deliver && armed_q && (len_q != '0);

  always_comb begin
    if (rd_q == data_i) begin
      count_new = count_q + CW'(1);
    end else if (first_q == data_i) begin
      count_new = CW'(1);
    end else begin
      count_new = '0;
    end
  end

  assign hit_o = cmd_i.deliver && armed_q && ((len_q == '0) || (count_new == len_q));

  always_comb begin
    count_d = count_q;
    len_d   = len_q;
    armed_d = armed_q;
    if (cmd_i.clear) begin
      count_d = '0;
      len_d   = '0;
      armed_d = 1'b0;
    end else if (cmd_i.arm) begin
      count_d = '0;
      len_d   = arm_len_i;
      armed_d = 1'b1;
    end else if (active) begin
      count_d = count_new;
    end
  end

  assign rd_addr = count_d[PW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      len_q   <= '0;
      armed_q <= 1'b0;
    end else begin
      count_q <= count_d;
      len_q   <= len_d;
      armed_q <= armed_d;
    end
  end

  // The read port always follows the next count, so rd_q holds the character
  // at the current count; a write to that address is forwarded.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= data_i;
    end
    if (cmd_i.wr_en && (wr_addr == rd_addr)) begin
      rd_q <= data_i;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && (pos_i == '0)) begin
      first_q <= data_i;
    end
  end

endmodule

[bench/mpsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_checker
// Watches both channels of the multi-pattern stream matcher, keeps its own
// copy of the slot state to work out the found slot of each stream byte, and
// compares every delivered result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mpsm_checker #(
  parameter int unsigned SLOTS           = 10,
  parameter int unsigned MAX_PATTERN_LEN = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [mpsm_pkg::REQ_W-1:0]      req_type_i,
  input  logic [mpsm_pkg::SLOT_W-1:0]     slot_i,
  input  logic [mpsm_pkg::POS_W-1:0]      position_i,
  input  logic [mpsm_pkg::BYTE_W-1:0]     value_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [mpsm_pkg::FOUND_W-1:0]    found_slot_i,
  output int unsigned                     outstanding_o,
  output int unsigned                     mismatches_o
);

  logic                           esc_pend;
  logic [mpsm_pkg::BYTE_W-1:0]    pat_chars [SLOTS][MAX_PATTERN_LEN];
  logic [5:0]                     pat_len   [SLOTS];
  logic                           armed     [SLOTS];
  logic [5:0]                     hit_count [SLOTS];
  logic [mpsm_pkg::FOUND_W-1:0]   found_q   [$];
  logic [mpsm_pkg::FOUND_W-1:0]   want_found;

  task automatic clear_slots();
    for (int s = 0; s < SLOTS; s++) begin
      armed[s]     = 1'b0;
      pat_len[s]   = '0;
      hit_count[s] = '0;
    end
  endtask

  task automatic scan_byte(input logic [mpsm_pkg::BYTE_W-1:0] b,
                           output logic [mpsm_pkg::FOUND_W-1:0] hit);
    int unsigned len, cnt;
    hit = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (armed[s]) begin
        len = pat_len[s];
        cnt = hit_count[s];
        if (len > 0) begin
          if (cnt >= len) cnt = 0;
          if (pat_chars[s][cnt] == b) cnt++;
          else if (pat_chars[s][0] == b) cnt = 1;
          else cnt = 0;
          hit_count[s] = cnt[5:0];
        end
        if (cnt == len && hit == '0) hit = mpsm_pkg::FOUND_W'(s + 1);
      end
    end
    if (hit != '0) clear_slots();
  endtask

  task automatic apply_item(input mpsm_pkg::req_e req,
                            input logic [mpsm_pkg::SLOT_W-1:0] s,
                            input logic [mpsm_pkg::POS_W-1:0] p,
                            input logic [mpsm_pkg::BYTE_W-1:0] v);
    logic [mpsm_pkg::FOUND_W-1:0] hit;
    hit = '0;
    case (req)
      mpsm_pkg::REQ_STREAM: begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          scan_byte(v - 8'd1, hit);
        end else if (v == mpsm_pkg::ESC_BYTE) begin
          esc_pend = 1'b1;
        end else begin
          scan_byte(v, hit);
        end
        found_q.push_back(hit);
      end
      mpsm_pkg::REQ_WRITE: begin
        if (s < SLOTS && p < MAX_PATTERN_LEN) pat_chars[s][p] = v;
      end
      mpsm_pkg::REQ_ARM: begin
        if (s < SLOTS) begin
          pat_len[s]   = (v > MAX_PATTERN_LEN) ? 6'(MAX_PATTERN_LEN) : v[5:0];
          armed[s]     = 1'b1;
          hit_count[s] = '0;
        end
      end
      default: clear_slots();
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_pend = 1'b0;
      clear_slots();
      found_q.delete();
      mismatches_o = 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (found_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual found_slot %0d",
                   $time, found_slot_i);
          mismatches_o++;
        end else begin
          want_found = found_q.pop_front();
          if (found_slot_i !== want_found) begin
            $display("%0t: found_slot mismatch, expected %0d, actual %0d",
                     $time, want_found, found_slot_i);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_item(mpsm_pkg::req_e'(req_type_i), slot_i, position_i, value_i);
      end
      outstanding_o <= found_q.size();
    end
  end

endmodule

[bench/multi_pattern_stream_matcher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_stream_matcher_tb
// Drives pattern loads, arms, clears and escaped or raw stream bytes into the
// matcher under changing sender gaps and receiver stalls, while a checker
// beside the block predicts and compares every found slot result.
// ----------------------------------------------------------------------------
module multi_pattern_stream_matcher_tb;

  localparam int unsigned SLOTS           = 10;
  localparam int unsigned MAX_PATTERN_LEN = 32;
  localparam int unsigned RANDOM_ITEMS    = 650;
  localparam int unsigned STALL_LIMIT     = 3000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [mpsm_pkg::REQ_W-1:0]     req_type = '0;
  logic [mpsm_pkg::SLOT_W-1:0]    slot = '0;
  logic [mpsm_pkg::POS_W-1:0]     position = '0;
  logic [mpsm_pkg::BYTE_W-1:0]    value = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [mpsm_pkg::FOUND_W-1:0]   found_slot;
  int unsigned                    outstanding;
  int unsigned                    mismatches;

  int unsigned          sender_idle_pct = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          items_sent = 0;
  int unsigned          quiet_cycles = 0;
  logic [MAX_PATTERN_LEN-1:0] written [SLOTS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_pattern_stream_matcher #(
    .SLOTS           (SLOTS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .slot_i       (slot),
    .position_i   (position),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .found_slot_o (found_slot)
  );

  mpsm_checker #(
    .SLOTS           (SLOTS),
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .req_type_i    (req_type),
    .slot_i        (slot),
    .position_i    (position),
    .value_i       (value),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .found_slot_i  (found_slot),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [mpsm_pkg::BYTE_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(15);
    if (r < 12) return 8'h61 + mpsm_pkg::BYTE_W'($urandom_range(2));
    if (r == 12) return mpsm_pkg::ESC_BYTE;
    if (r == 13) return 8'hFF;
    if (r == 14) return 8'h00;
    return mpsm_pkg::BYTE_W'($urandom_range(255));
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(6, MAX_PATTERN_LEN);
    if (r == 2) return $urandom_range(MAX_PATTERN_LEN + 1, 255);
    return $urandom_range(1, 5);
  endfunction

  task automatic send_item(input mpsm_pkg::req_e req,
                           input logic [mpsm_pkg::SLOT_W-1:0] s,
                           input logic [mpsm_pkg::POS_W-1:0] p,
                           input logic [mpsm_pkg::BYTE_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    slot     <= s;
    position <= p;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req == mpsm_pkg::REQ_STREAM || req == mpsm_pkg::REQ_CLEAR || s < SLOTS) items_sent++;
  endtask

  task automatic send_byte(input logic [mpsm_pkg::BYTE_W-1:0] b, input bit escaped);
    if (escaped || b == mpsm_pkg::ESC_BYTE) begin
      send_item(mpsm_pkg::REQ_STREAM, mpsm_pkg::SLOT_W'($urandom_range(15)),
                mpsm_pkg::POS_W'($urandom_range(31)), mpsm_pkg::ESC_BYTE);
      send_item(mpsm_pkg::REQ_STREAM, mpsm_pkg::SLOT_W'($urandom_range(15)),
                mpsm_pkg::POS_W'($urandom_range(31)), b + 8'd1);
    end else begin
      send_item(mpsm_pkg::REQ_STREAM, mpsm_pkg::SLOT_W'($urandom_range(15)),
                mpsm_pkg::POS_W'($urandom_range(31)), b);
    end
  endtask

  task automatic write_char(input logic [mpsm_pkg::SLOT_W-1:0] s,
                            input logic [mpsm_pkg::POS_W-1:0] p,
                            input logic [mpsm_pkg::BYTE_W-1:0] v);
    send_item(mpsm_pkg::REQ_WRITE, s, p, v);
    if (s < SLOTS) written[s][p] = 1'b1;
  endtask

  // Characters the new length would compare against are written first.
  task automatic arm_slot(input logic [mpsm_pkg::SLOT_W-1:0] s,
                          input logic [mpsm_pkg::BYTE_W-1:0] v);
    int unsigned eff;
    eff = (v > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : v;
    if (s < SLOTS) begin
      for (int p = 0; p < eff; p++) begin
        if (!written[s][p]) write_char(s, mpsm_pkg::POS_W'(p), pick_char());
      end
    end
    send_item(mpsm_pkg::REQ_ARM, s, mpsm_pkg::POS_W'($urandom_range(31)), v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_pattern();
    logic [mpsm_pkg::SLOT_W-1:0]  s;
    logic [mpsm_pkg::BYTE_W-1:0]  pat [MAX_PATTERN_LEN];
    int unsigned                  len_val, eff, bad;
    s = mpsm_pkg::SLOT_W'($urandom_range(SLOTS - 1));
    len_val = pick_length();
    eff = (len_val > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : len_val;
    for (int p = 0; p < eff; p++) begin
      pat[p] = pick_char();
      write_char(s, mpsm_pkg::POS_W'(p), pat[p]);
    end
    arm_slot(s, mpsm_pkg::BYTE_W'(len_val));
    repeat ($urandom_range(3)) send_byte(pick_char(), $urandom_range(7) == 0);
    bad = ($urandom_range(3) == 0) ? $urandom_range(eff) : eff;
    for (int p = 0; p < eff; p++) begin
      send_byte((p == bad) ? pick_char() : pat[p], $urandom_range(7) == 0);
    end
    if ($urandom_range(1) == 1) send_byte(pick_char(), 1'b0);
  endtask

  initial begin
    int unsigned phase, next_phase, r;
    for (int s = 0; s < SLOTS; s++) written[s] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_char(0, 0, 8'h61);
    write_char(0, 1, 8'h62);
    arm_slot(0, 2);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    write_char(9, 31, 8'h00);
    write_char(9, 0, 8'hFF);
    arm_slot(9, 1);
    send_item(mpsm_pkg::REQ_STREAM, 0, 0, mpsm_pkg::ESC_BYTE);
    send_item(mpsm_pkg::REQ_STREAM, 15, 31, 8'h00);
    write_char(15, 31, 8'hAA);
    send_item(mpsm_pkg::REQ_ARM, 15, 31, 8'hFF);
    arm_slot(1, 8'hFF);
    arm_slot(2, 0);
    send_byte(8'h7A, 1'b0);
    arm_slot(0, 2);
    send_byte(8'h61, 1'b0);
    write_char(0, 1, 8'h71);
    send_byte(8'h71, 1'b0);
    arm_slot(0, 2);
    send_item(mpsm_pkg::REQ_STREAM, 0, 0, mpsm_pkg::ESC_BYTE);
    send_item(mpsm_pkg::REQ_CLEAR, 0, 0, 8'h00);
    send_item(mpsm_pkg::REQ_STREAM, 0, 0, 8'h62);
    send_byte(8'h62, 1'b0);
    drain();

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      next_phase = items_sent * 4 / RANDOM_ITEMS;
      if (next_phase != phase) begin
        drain();
        phase = next_phase;
        case (phase)
          1: begin
            sender_idle_pct = 71;
            recv_stall_pct  = 0;
          end
          2: begin
            sender_idle_pct = 0;
            recv_stall_pct  = 71;
          end
          default: begin
            sender_idle_pct = 15;
            recv_stall_pct  = 15;
          end
        endcase
      end
      r = $urandom_range(99);
      if (r < 55) begin
        run_pattern();
      end else if (r < 75) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(mpsm_pkg::REQ_STREAM, mpsm_pkg::SLOT_W'($urandom_range(15)),
                    mpsm_pkg::POS_W'($urandom_range(31)),
                    mpsm_pkg::BYTE_W'($urandom_range(255)));
        end
      end else if (r < 83) begin
        send_item(mpsm_pkg::REQ_CLEAR, mpsm_pkg::SLOT_W'($urandom_range(15)),
                  mpsm_pkg::POS_W'($urandom_range(31)),
                  mpsm_pkg::BYTE_W'($urandom_range(255)));
      end else if (r < 93) begin
        write_char(mpsm_pkg::SLOT_W'($urandom_range(15)),
                   mpsm_pkg::POS_W'($urandom_range(31)),
                   mpsm_pkg::BYTE_W'($urandom_range(255)));
      end else begin
        arm_slot(mpsm_pkg::SLOT_W'($urandom_range(15)), mpsm_pkg::BYTE_W'(pick_length()));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
